FILE: hw/rtl/rlcd_pkg.sv
// Shared constants, types and the square-root digit step for the color distance block.
// Used by rlcd_sqrt_pipe and rgb_linear_lab_color_distance; no dependencies.
`timescale 1ns / 1ps
`default_nettype none

package rlcd_pkg;

  // Channel and datapath widths
  localparam int ChanW   = 8;
  localparam int ColorW  = 3 * ChanW;
  localparam int DiffW   = ChanW + 1;        // signed channel difference
  localparam int CoefW   = 21;               // signed Q20 coefficient
  localparam int ProdW   = 30;               // coef * diff and sums of three
  localparam int MagW    = 29;               // |delta|
  localparam int SqW     = 2 * MagW;         // squared magnitude
  localparam int SumW    = SqW + 2;          // sum of three squares
  localparam int DropW   = 24;               // 2 * (20 - 8) fraction bits dropped
  localparam int RadW    = SumW - DropW;     // radicand for the Q8 root
  localparam int RootW   = RadW / 2;         // equals the distance width
  localparam int RemW    = RootW + 3;
  localparam int StepsPerStage = 2;
  localparam int SqrtStages    = RootW / StepsPerStage;

  // Q20 coefficients per channel count, index = 3 * component + channel,
  // components L, a, b and channels red, green, blue.
  localparam logic signed [CoefW-1:0] Coef [9] = '{
    21'sd101410,  21'sd341150,  21'sd34439,
    21'sd454980, -21'sd696923,  21'sd242007,
    21'sd160267,  21'sd498156, -21'sd658551
  };

  typedef logic [RadW-1:0]  rad_t;
  typedef logic [RootW-1:0] root_t;

  typedef struct packed {
    logic [RemW-1:0]  rem;
    logic [RootW-1:0] root;
  } sqrt_acc_t;

  // One restoring square-root digit: brings in two radicand bits.
  function automatic sqrt_acc_t sqrt_step(sqrt_acc_t acc, logic [1:0] pair);
    logic [RemW-1:0] trial;
    logic [RemW-1:0] test;
    sqrt_acc_t       res;
    trial = {acc.rem[RemW-3:0], pair};
    test  = {1'b0, acc.root, 2'b01};
    if (trial >= test) begin
      res.rem  = trial - test;
      res.root = {acc.root[RootW-2:0], 1'b1};
    end else begin
      res.rem  = trial;
      res.root = {acc.root[RootW-2:0], 1'b0};
    end
    return res;
  endfunction

endpackage

`default_nettype wire

FILE: hw/rtl/rlcd_sqrt_pipe.sv
// Pipelined truncated integer square root, two root bits per register stage.
// Depends on rlcd_pkg for widths and the digit step.
`timescale 1ns / 1ps
`default_nettype none

module rlcd_sqrt_pipe
  import rlcd_pkg::*;
(
  input  wire logic  clk_i,
  input  wire logic  rst_ni,
  input  wire logic  valid_i,
  input  wire rad_t  radicand_i,
  output logic       valid_o,
  output root_t      root_o
);

  logic      vld_q [SqrtStages];
  sqrt_acc_t acc_q [SqrtStages];
  rad_t      rad_q [SqrtStages];

  for (genvar s = 0; s < SqrtStages; s++) begin : g_stage
    logic      vld_in;
    sqrt_acc_t acc_in;
    rad_t      rad_in;
    sqrt_acc_t acc_d;
    rad_t      rad_d;

    if (s == 0) begin : g_first
      assign vld_in = valid_i;
      assign acc_in = '0;
      assign rad_in = radicand_i;
    end else begin : g_next
      assign vld_in = vld_q[s-1];
      assign acc_in = acc_q[s-1];
      assign rad_in = rad_q[s-1];
    end

    always_comb begin
      acc_d = acc_in;
      rad_d = rad_in;
      for (int k = 0; k < StepsPerStage; k++) begin
        acc_d = sqrt_step(acc_d, rad_d[RadW-1 -: 2]);
        rad_d = {rad_d[RadW-3:0], 2'b00};
      end
    end

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        vld_q[s] <= 1'b0;
      end else begin
        vld_q[s] <= vld_in;
      end
    end

    always_ff @(posedge clk_i) begin
      acc_q[s] <= acc_d;
      rad_q[s] <= rad_d;
    end
  end

  assign valid_o = vld_q[SqrtStages-1];
  assign root_o  = acc_q[SqrtStages-1].root;

endmodule

`default_nettype wire

FILE: hw/rtl/rgb_linear_lab_color_distance.sv
// Top level: linear Lab-style (CIE76 form) distance between two packed RGB colors.
// Depends on rlcd_pkg and rlcd_sqrt_pipe.
`timescale 1ns / 1ps
`default_nettype none

// Usage
//   Command channel: drive color_a_i / color_b_i and raise start_i; a beat is
//   taken at each rising edge with start_i high and busy_o low. busy_o is
//   always low: the datapath is a fully pipelined chain, so a new pair can
//   be issued every clock.
//   Result channel: done_o pulses for one cycle with distance_o (Q8, root
//   truncated). Results come out in issue order, one per command.
//   Pipeline: 5 arithmetic stages (channel diffs, coefficient products,
//   sums of three, squares, sum of squares) then 9 square-root stages that
//   each resolve two root bits. The square-root chain sets the depth.
//   Throughput: one pair per cycle.
//   Reset clears every valid bit; pairs in flight are dropped, payload
//   registers are left as they are. The receiver cannot stall, so there
//   is no backpressure path anywhere in the pipe.
//   Arithmetic: each delta (L, a, b) is a sum of Q20 coefficients times
//   the signed channel differences; the root is taken of the sum of
//   squares with the 24 low bits dropped, which equals the Q20 root
//   shifted down to Q8.

module rgb_linear_lab_color_distance
  import rlcd_pkg::*;
(
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              start_i,
  output logic                   busy_o,
  input  wire logic [ColorW-1:0] color_a_i,
  input  wire logic [ColorW-1:0] color_b_i,
  output logic                   done_o,
  output logic [RootW-1:0]       distance_o
);

  assign busy_o = 1'b0;

  logic accept;
  assign accept = start_i && !busy_o;

  // Stage valid bits
  logic v1_q, v2_q, v3_q, v4_q, v5_q;

  // Stage 1: signed channel differences
  logic signed [DiffW-1:0] diff_d [3];
  logic signed [DiffW-1:0] diff_q [3];

  always_comb begin
    for (int c = 0; c < 3; c++) begin
      diff_d[c] = signed'({1'b0, color_a_i[ColorW-1-ChanW*c -: ChanW]})
                - signed'({1'b0, color_b_i[ColorW-1-ChanW*c -: ChanW]});
    end
  end

  // Stage 2: nine coefficient products
  logic signed [ProdW-1:0] prod_d [9];
  logic signed [ProdW-1:0] prod_q [9];

  always_comb begin
    for (int i = 0; i < 9; i++) begin
      prod_d[i] = ProdW'(Coef[i]) * ProdW'(diff_q[i % 3]);
    end
  end

  // Stage 3: deltas L, a, b
  logic signed [ProdW-1:0] delta_d [3];
  logic signed [ProdW-1:0] delta_q [3];

  always_comb begin
    for (int j = 0; j < 3; j++) begin
      delta_d[j] = prod_q[3*j] + prod_q[3*j+1] + prod_q[3*j+2];
    end
  end

  // Stage 4: squared magnitudes
  logic [MagW-1:0] mag [3];
  logic [SqW-1:0]  sq_d [3];
  logic [SqW-1:0]  sq_q [3];

  always_comb begin
    for (int j = 0; j < 3; j++) begin
      mag[j]  = delta_q[j][ProdW-1] ? MagW'(-delta_q[j]) : MagW'(delta_q[j]);
      sq_d[j] = SqW'(mag[j]) * SqW'(mag[j]);
    end
  end

  // Stage 5: sum of squares, low fraction bits dropped
  logic [SumW-1:0] sum_d;
  rad_t            rad_q;

  assign sum_d = SumW'(sq_q[0]) + SumW'(sq_q[1]) + SumW'(sq_q[2]);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      v3_q <= 1'b0;
      v4_q <= 1'b0;
      v5_q <= 1'b0;
    end else begin
      v1_q <= accept;
      v2_q <= v1_q;
      v3_q <= v2_q;
      v4_q <= v3_q;
      v5_q <= v4_q;
    end
  end

  always_ff @(posedge clk_i) begin
    diff_q  <= diff_d;
    prod_q  <= prod_d;
    delta_q <= delta_d;
    sq_q    <= sq_d;
    rad_q   <= sum_d[SumW-1:DropW];
  end

  // Stages 6..14: square root
  rlcd_sqrt_pipe u_sqrt (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .valid_i    (v5_q),
    .radicand_i (rad_q),
    .valid_o    (done_o),
    .root_o     (distance_o)
  );

  // Every accepted beat yields exactly one strobe, at fixed latency.
  localparam int Latency = 5 + SqrtStages;

  a_accept_to_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept |-> ##Latency done_o)
    else $error("accepted beat produced no result at expected latency");

  a_done_from_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> $past(accept, Latency))
    else $error("result strobe without a matching accepted beat");

  a_zero_diff: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (accept && color_a_i == color_b_i) |-> ##Latency (distance_o == '0))
    else $error("identical colors gave nonzero distance");

endmodule

`default_nettype wire

FILE: test/tb_rgb_linear_lab_color_distance.sv
// Testbench for rgb_linear_lab_color_distance: streams color pairs through the
// command port and checks each distance against an in-bench Q8 predictor.
// Depends on rlcd_pkg and the RTL of the block.
`timescale 1ns / 1ps

module tb_rgb_linear_lab_color_distance;
  import rlcd_pkg::*;

  // Delta components and color channels, used to pick a coefficient.
  localparam int CompL = 0;
  localparam int CompA = 1;
  localparam int CompB = 2;
  localparam int ChRed   = 0;
  localparam int ChGreen = 1;
  localparam int ChBlue  = 2;

  localparam longint OneQ20     = longint'(1) << 20;
  localparam int     RandPairs  = 1000;
  localparam int     DrainLimit = 200;  // cycles allowed for the pipe to empty
  localparam int     SettleCyc  = 20;   // a margin over the pipeline latency
  localparam int     ShowMax    = 10;

  // One entry of the stimulus queue: either a color pair or one idle beat.
  // Idle entries still carry random colors so the data ports move while
  // start_i is low.
  typedef struct packed {
    logic              is_gap;
    logic [ColorW-1:0] color_a;
    logic [ColorW-1:0] color_b;
  } pair_beat_t;

  logic              clk_i;
  logic              rst_ni    = 1'b0;
  logic              start_i   = 1'b0;
  logic [ColorW-1:0] color_a_i = '0;
  logic [ColorW-1:0] color_b_i = '0;
  logic              busy_o;
  logic              done_o;
  logic [RootW-1:0]  distance_o;

  pair_beat_t       pair_pending_q [$];
  logic [RootW-1:0] distance_due_q [$];
  int               error_count = 0;

  rgb_linear_lab_color_distance DUT (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (start_i),
    .busy_o     (busy_o),
    .color_a_i  (color_a_i),
    .color_b_i  (color_b_i),
    .done_o     (done_o),
    .distance_o (distance_o)
  );

  initial begin
    clk_i = 1'b0;
    forever #6 clk_i = ~clk_i;
  end

  // ---------------------------------------------------------------------
  // Predictor
  // ---------------------------------------------------------------------

  // Integer division rounded to nearest, halves away from zero.
  function automatic longint div_round(longint num, longint den);
    if (num >= 0) begin
      return (num + den / 2) / den;
    end
    return -((-num + den / 2) / den);
  endfunction

  // Q20 weight per channel count for one delta component. Weights are the
  // XYZ matrix rows in units of 1e-4; white point Xn = 0.95047, Zn = 1.08883.
  // All three components are linear in the channel difference, so the
  // whole chain folds into one rational coefficient per channel.
  function automatic longint lab_coef(int comp, int ch);
    longint wx;
    longint wy;
    longint wz;
    case (ch)
      ChRed: begin
        wx = 4124; wy = 2126; wz = 193;
      end
      ChGreen: begin
        wx = 3576; wy = 7152; wz = 1192;
      end
      default: begin
        wx = 1805; wy = 722;  wz = 9505;
      end
    endcase
    case (comp)
      CompL:   return div_round(OneQ20 * 116 * wy, 64'sd10000 * 255);
      CompA:   return div_round(OneQ20 * 500 * (wx * 100000 - wy * 95047),
                                64'sd95047 * 10000 * 255);
      default: return div_round(OneQ20 * 200 * (wy * 108883 - wz * 100000),
                                64'sd108883 * 10000 * 255);
    endcase
  endfunction

  // floor(sqrt(v)), one root bit per pass from the top down.
  function automatic longint unsigned floor_root(longint unsigned v);
    longint unsigned root;
    longint unsigned trial;
    root = 0;
    for (int i = 31; i >= 0; i--) begin
      trial = root | (longint'(1) << i);
      if (trial * trial <= v) begin
        root = trial;
      end
    end
    return root;
  endfunction

  // CIE76-style distance of two packed colors in Q8, root truncated.
  function automatic logic [RootW-1:0] lab_distance_q8(logic [ColorW-1:0] ca,
                                                       logic [ColorW-1:0] cb);
    longint          chan_diff [3];
    longint          delta [3];
    longint unsigned sum_sq;
    longint unsigned root_q20;
    for (int ch = 0; ch < 3; ch++) begin
      chan_diff[ch] = longint'(ca[16 - 8 * ch +: 8]) - longint'(cb[16 - 8 * ch +: 8]);
    end
    sum_sq = 0;
    for (int comp = 0; comp < 3; comp++) begin
      delta[comp] = 0;
      for (int ch = 0; ch < 3; ch++) begin
        delta[comp] += lab_coef(comp, ch) * chan_diff[ch];
      end
      sum_sq += longint'(delta[comp] * delta[comp]);
    end
    root_q20 = floor_root(sum_sq);
    // Q20 root down to Q8; the value stays well under 2^9.
    return root_q20[RootW + 11:12];
  endfunction

  // ---------------------------------------------------------------------
  // Driver: one beat per accepted edge, idle entries lower start_i.
  // Expectations are queued at the accepting edge so ordering matches
  // issue order.
  // ---------------------------------------------------------------------
  always @(posedge clk_i) begin : drive
    pair_beat_t nxt;
    if (rst_ni) begin
      if (start_i && !busy_o) begin
        distance_due_q.push_back(lab_distance_q8(color_a_i, color_b_i));
      end
      // Hold the current beat while busy; otherwise move to the next entry.
      if (!(start_i && busy_o)) begin
        if (pair_pending_q.size() != 0) begin
          nxt = pair_pending_q.pop_front();
          start_i   <= !nxt.is_gap;
          color_a_i <= nxt.color_a;
          color_b_i <= nxt.color_b;
        end else begin
          start_i <= 1'b0;
        end
      end
    end
  end

  // ---------------------------------------------------------------------
  // Monitor: every done_o pulse is one result beat, compared against the
  // oldest expectation. No backpressure, so nothing to stall here.
  // ---------------------------------------------------------------------
  always @(posedge clk_i) begin : check
    logic [RootW-1:0] want;
    if (rst_ni && done_o) begin
      if (distance_due_q.size() == 0) begin
        if (error_count < ShowMax) begin
          $display("[%0t] unexpected result beat: distance=%0d", $realtime, distance_o);
        end
        error_count++;
      end else begin
        want = distance_due_q.pop_front();
        if (distance_o !== want) begin
          if (error_count < ShowMax) begin
            $display("[%0t] distance mismatch: expected %0d (0x%05h) got %0d (0x%05h)",
                     $realtime, want, want, distance_o, distance_o);
          end
          error_count++;
        end
      end
    end
  end

  // ---------------------------------------------------------------------
  // Stimulus helpers
  // ---------------------------------------------------------------------
  task automatic add_pair(logic [ColorW-1:0] ca, logic [ColorW-1:0] cb);
    pair_beat_t b;
    b.is_gap  = 1'b0;
    b.color_a = ca;
    b.color_b = cb;
    pair_pending_q.push_back(b);
  endtask

  task automatic add_idle_burst();
    pair_beat_t b;
    int         len;
    len = $urandom_range(1, 9);
    for (int i = 0; i < len; i++) begin
      b.is_gap  = 1'b1;
      b.color_a = ColorW'($urandom);
      b.color_b = ColorW'($urandom);
      pair_pending_q.push_back(b);
    end
  endtask

  // Channel value moved by a small random step, clamped to 0..255.
  function automatic logic [7:0] nudge(logic [7:0] chan);
    int v;
    v = int'(chan) + $urandom_range(0, 8) - 4;
    if (v < 0) v = 0;
    if (v > 255) v = 255;
    return v[7:0];
  endfunction

  // ---------------------------------------------------------------------
  // Main sequence
  // ---------------------------------------------------------------------
  initial begin : main
    logic [ColorW-1:0] ca;
    logic [ColorW-1:0] cb;
    int                kind;
    int                idle_odds;
    int                drain;

    // Directed: zero distance, full-scale pairs both ways, each channel
    // alone, opposite-sign channel mixes, alternating bit patterns and
    // the smallest nonzero steps.
    add_pair(24'h000000, 24'h000000);
    add_pair(24'hFFFFFF, 24'hFFFFFF);
    add_pair(24'hFFFFFF, 24'h000000);
    add_pair(24'h000000, 24'hFFFFFF);
    add_pair(24'hFF0000, 24'h000000);
    add_pair(24'h000000, 24'hFF0000);
    add_pair(24'h00FF00, 24'h000000);
    add_pair(24'h000000, 24'h00FF00);
    add_pair(24'h0000FF, 24'h000000);
    add_pair(24'h000000, 24'h0000FF);
    add_pair(24'hFF0000, 24'h00FF00);
    add_pair(24'h00FF00, 24'h0000FF);
    add_pair(24'h0000FF, 24'hFF0000);
    add_pair(24'hFF00FF, 24'h00FF00);
    add_pair(24'h00FFFF, 24'hFF0000);
    add_pair(24'hFFFF00, 24'h0000FF);
    add_pair(24'hAAAAAA, 24'h555555);
    add_pair(24'h555555, 24'hAAAAAA);
    add_pair(24'h010101, 24'h000000);
    add_pair(24'h000001, 24'h000000);
    add_pair(24'h7F7F7F, 24'h808080);
    add_pair(24'h123456, 24'h123456);

    // Random part in four phases: bursty, back-to-back, bursty, and a
    // final stretch at full rate.
    for (int n = 0; n < RandPairs; n++) begin
      kind = $urandom_range(0, 99);
      ca   = ColorW'($urandom);
      if (kind < 40) begin
        cb = ColorW'($urandom);
      end else if (kind < 70) begin
        // close colors: the typical image-search case
        cb = {nudge(ca[23:16]), nudge(ca[15:8]), nudge(ca[7:0])};
      end else if (kind < 85) begin
        // at most one channel differs
        cb = ca;
        case ($urandom_range(0, 2))
          ChRed:   cb[23:16] = 8'($urandom);
          ChGreen: cb[15:8]  = 8'($urandom);
          default: cb[7:0]   = 8'($urandom);
        endcase
      end else begin
        // channels pinned at the rails
        for (int ch = 0; ch < 3; ch++) begin
          ca[8 * ch +: 8] = $urandom_range(0, 1) ? 8'hFF : 8'h00;
          cb[8 * ch +: 8] = $urandom_range(0, 1) ? 8'hFF : 8'h00;
        end
      end

      if (n < 300 || (n >= 450 && n < 850)) idle_odds = 3;
      else idle_odds = 0;
      if (idle_odds != 0 && $urandom_range(0, idle_odds - 1) == 0) begin
        add_idle_burst();
      end
      add_pair(ca, cb);
    end

    // Reset: held low from time zero, released once.
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;

    // Wait for the last beat to be accepted, then for the pipe to drain.
    while (pair_pending_q.size() != 0 || start_i) @(posedge clk_i);
    drain = 0;
    while (distance_due_q.size() != 0 && drain < DrainLimit) begin
      @(posedge clk_i);
      drain++;
    end
    repeat (SettleCyc) @(posedge clk_i);

    if (distance_due_q.size() != 0) begin
      if (error_count < ShowMax) begin
        $display("%0d expected results never arrived", distance_due_q.size());
      end
      error_count++;
    end

    if (error_count == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

  // Watchdog, far beyond the slowest legal run.
  initial begin : watchdog
    #2_000_000;
    $display("Some tests failed");
    $finish;
  end

endmodule

FILE: sim.f
hw/rtl/rlcd_pkg.sv
hw/rtl/rlcd_sqrt_pipe.sv
hw/rtl/rgb_linear_lab_color_distance.sv
test/tb_rgb_linear_lab_color_distance.sv
